>>> rtl/core/smpq_pkg.sv
package smpq_pkg;

    localparam int DATA_W   = 32;
    localparam int CLIP_W   = 31;
    localparam int LEVEL_W  = 8;

    localparam logic [CLIP_W-1:0] CLIP_RESET = 31'd65536;

    // magnitude path
    localparam int SQ_W      = 64;
    localparam int SCALE_W   = 18;
    localparam logic [SCALE_W-1:0] SCALE_SQ = 18'd260100;   // 510 squared
    localparam int PROD_W    = 32 + SCALE_W;
    localparam int ROOT_W    = 41;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int ACC_W     = 42;
    localparam int LVL_STEPS = 8;
    localparam int MAG_LAT   = 4 + ROOT_W + LVL_STEPS;

    // phase path
    localparam int PH_STEPS  = 7;
    localparam int PH_LAT    = 1 + 2 * PH_STEPS;
    localparam int PH_PAD    = MAG_LAT - PH_LAT;
    localparam int TBL_N     = 64;
    localparam int TBL_IDX_W = 6;

    localparam logic [LEVEL_W-1:0] PHASE_POS  = 8'd191;
    localparam logic [LEVEL_W-1:0] PHASE_NEG  = 8'd64;
    localparam logic [LEVEL_W-1:0] PHASE_ZERO = 8'd128;
    localparam logic [LEVEL_W-1:0] PHASE_BASE = 8'd64;

    localparam logic [63:0] PI_Q40 = 64'h0000_0324_3F6A_8885;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef struct packed {
        logic signed [DATA_W-1:0] real_part;
        logic signed [DATA_W-1:0] imag_part;
    } t_req;

    typedef struct packed {
        logic [LEVEL_W-1:0] magnitude_level;
        logic [LEVEL_W-1:0] phase_level;
    } t_res;

    typedef logic signed [31:0] t_trig;
    typedef t_trig t_trig_tbl [TBL_N];

    // truncating taylor series, q30, angle 2*pi*j/255
    function automatic t_trig_tbl build_sine();
        logic [63:0] x;
        logic [63:0] term;
        logic signed [63:0] acc;
        t_trig_tbl tbl;
        for (int j = 0; j < TBL_N; j++) begin
            x = ((PI_Q40 * 64'(2 * j)) / 64'd255) >> 10;
            term = x;
            acc = signed'(x);
            for (int n = 1; n <= 15; n++) begin
                term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    acc = acc - signed'(term);
                end else begin
                    acc = acc + signed'(term);
                end
            end
            tbl[j] = t_trig'(acc[31:0]);
        end
        return tbl;
    endfunction

    function automatic t_trig_tbl build_cosine();
        logic [63:0] x;
        logic [63:0] term;
        logic signed [63:0] acc;
        t_trig_tbl tbl;
        for (int j = 0; j < TBL_N; j++) begin
            x = ((PI_Q40 * 64'(2 * j)) / 64'd255) >> 10;
            term = ONE_Q30;
            acc = signed'(ONE_Q30);
            for (int n = 1; n <= 15; n++) begin
                term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n % 2) == 1) begin
                    acc = acc - signed'(term);
                end else begin
                    acc = acc + signed'(term);
                end
            end
            tbl[j] = t_trig'(acc[31:0]);
        end
        return tbl;
    endfunction

    localparam t_trig_tbl SINE_TBL   = build_sine();
    localparam t_trig_tbl COSINE_TBL = build_cosine();

endpackage

>>> rtl/core/smpq_isqrt.sv
module smpq_isqrt (
    input  logic                        i_clk,
    input  logic [smpq_pkg::RAD_W-1:0]  i_rad,
    output logic [smpq_pkg::ROOT_W-1:0] o_root
);
    import smpq_pkg::*;

    // one root bit per stage
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  n_rad  [ROOT_W];
    logic [REM_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];
    logic [RAD_W-1:0]  s_rad  [ROOT_W];
    logic [REM_W-1:0]  s_rem  [ROOT_W];
    logic [ROOT_W-1:0] s_root [ROOT_W];

    always_comb begin
        s_rad[0]  = i_rad;
        s_rem[0]  = '0;
        s_root[0] = '0;
        for (int k = 1; k < ROOT_W; k++) begin
            s_rad[k]  = r_rad[k-1];
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
        end
    end

    always_comb begin
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        for (int k = 0; k < ROOT_W; k++) begin
            rem_sh = {s_rem[k][REM_W-3:0], s_rad[k][RAD_W-1:RAD_W-2]};
            trial  = {s_root[k], 2'b01};
            n_rad[k] = {s_rad[k][RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem[k]  = rem_sh - trial;
                n_root[k] = {s_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = rem_sh;
                n_root[k] = {s_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ROOT_W; k++) begin
            r_rad[k]  <= n_rad[k];
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

>>> rtl/core/smpq_mag.sv
module smpq_mag (
    input  logic                         i_clk,
    input  smpq_pkg::t_req               i_req,
    input  logic [smpq_pkg::CLIP_W-1:0]  i_clip,
    output logic [smpq_pkg::LEVEL_W-1:0] o_level
);
    import smpq_pkg::*;

    logic [SQ_W-2:0]   r_re2;
    logic [SQ_W-2:0]   r_im2;
    logic [SQ_W-1:0]   r_sum;
    logic [PROD_W-1:0] r_plo;
    logic [PROD_W-1:0] r_phi;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] w_root;

    logic signed [SQ_W-1:0] n_re2;
    logic signed [SQ_W-1:0] n_im2;

    always_comb begin
        n_re2 = SQ_W'(i_req.real_part) * SQ_W'(i_req.real_part);
        n_im2 = SQ_W'(i_req.imag_part) * SQ_W'(i_req.imag_part);
    end

    always_ff @(posedge i_clk) begin
        r_re2 <= n_re2[SQ_W-2:0];
        r_im2 <= n_im2[SQ_W-2:0];
        r_sum <= SQ_W'(r_re2) + SQ_W'(r_im2);
        r_plo <= PROD_W'(r_sum[31:0]) * PROD_W'(SCALE_SQ);
        r_phi <= PROD_W'(r_sum[63:32]) * PROD_W'(SCALE_SQ);
        r_rad <= (RAD_W'(r_phi) << 32) + RAD_W'(r_plo);
    end

    smpq_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    // level = largest v with (2v-1)*clip <= root, one bit a stage
    logic [LEVEL_W-1:0] r_v   [LVL_STEPS];
    logic [ACC_W-1:0]   r_acc [LVL_STEPS];
    logic [ROOT_W-1:0]  r_q   [LVL_STEPS];
    logic [LEVEL_W-1:0] s_v   [LVL_STEPS];
    logic [ACC_W-1:0]   s_acc [LVL_STEPS];
    logic [ROOT_W-1:0]  s_q   [LVL_STEPS];
    logic [LEVEL_W-1:0] n_v   [LVL_STEPS];
    logic [ACC_W-1:0]   n_acc [LVL_STEPS];

    always_comb begin
        s_v[0]   = '0;
        s_acc[0] = '0;
        s_q[0]   = w_root;
        for (int k = 1; k < LVL_STEPS; k++) begin
            s_v[k]   = r_v[k-1];
            s_acc[k] = r_acc[k-1];
            s_q[k]   = r_q[k-1];
        end
    end

    always_comb begin
        logic [ACC_W-1:0] step;
        logic [ACC_W-1:0] cand;
        logic [ACC_W-1:0] test;
        for (int k = 0; k < LVL_STEPS; k++) begin
            step = ACC_W'(i_clip) << (LVL_STEPS - 1 - k);
            cand = s_acc[k] + step;
            test = (cand << 1) - ACC_W'(i_clip);
            if (test <= ACC_W'(s_q[k])) begin
                n_v[k]   = s_v[k] | (LEVEL_W'(1) << (LVL_STEPS - 1 - k));
                n_acc[k] = cand;
            end else begin
                n_v[k]   = s_v[k];
                n_acc[k] = s_acc[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LVL_STEPS; k++) begin
            r_v[k]   <= n_v[k];
            r_acc[k] <= n_acc[k];
            r_q[k]   <= s_q[k];
        end
    end

    assign o_level = r_v[LVL_STEPS-1];

endmodule

>>> rtl/core/smpq_phase.sv
module smpq_phase (
    input  logic                         i_clk,
    input  smpq_pkg::t_req               i_req,
    output logic [smpq_pkg::LEVEL_W-1:0] o_level
);
    import smpq_pkg::*;

    localparam int CNT_W = PH_STEPS;
    localparam int OP_W  = DATA_W + 1;
    localparam int MUL_W = OP_W + 32;

    // front stage: fold to the right half plane
    logic signed [OP_W-1:0] r_d0;
    logic signed [OP_W-1:0] r_n0;
    logic                   r_fix0;
    logic [LEVEL_W-1:0]     r_fixlvl0;

    always_ff @(posedge i_clk) begin
        if (i_req.real_part < 0) begin
            r_d0 <= -OP_W'(i_req.real_part);
            r_n0 <= -OP_W'(i_req.imag_part);
        end else begin
            r_d0 <= OP_W'(i_req.real_part);
            r_n0 <= OP_W'(i_req.imag_part);
        end
        r_fix0 <= (i_req.real_part == 0);
        if (i_req.imag_part > 0) begin
            r_fixlvl0 <= PHASE_POS;
        end else if (i_req.imag_part < 0) begin
            r_fixlvl0 <= PHASE_NEG;
        end else begin
            r_fixlvl0 <= PHASE_ZERO;
        end
    end

    // binary search over thresholds, multiply stage then compare stage
    logic signed [OP_W-1:0]  r_d     [2*PH_STEPS];
    logic signed [OP_W-1:0]  r_n     [2*PH_STEPS];
    logic                    r_fix   [2*PH_STEPS];
    logic [LEVEL_W-1:0]      r_fixlvl[2*PH_STEPS];
    logic [CNT_W-1:0]        r_cnt   [2*PH_STEPS];
    logic [CNT_W-1:0]        r_try   [PH_STEPS];
    logic signed [MUL_W-1:0] r_p1    [PH_STEPS];
    logic signed [MUL_W-1:0] r_p2    [PH_STEPS];

    logic signed [OP_W-1:0]  s_d     [PH_STEPS];
    logic signed [OP_W-1:0]  s_n     [PH_STEPS];
    logic                    s_fix   [PH_STEPS];
    logic [LEVEL_W-1:0]      s_fixlvl[PH_STEPS];
    logic [CNT_W-1:0]        s_cnt   [PH_STEPS];
    logic [CNT_W-1:0]        n_try   [PH_STEPS];
    logic signed [MUL_W-1:0] n_p1    [PH_STEPS];
    logic signed [MUL_W-1:0] n_p2    [PH_STEPS];
    logic [CNT_W-1:0]        n_cnt   [PH_STEPS];

    always_comb begin
        s_d[0] = r_d0;
        s_n[0] = r_n0;
        s_fix[0] = r_fix0;
        s_fixlvl[0] = r_fixlvl0;
        s_cnt[0] = '0;
        for (int k = 1; k < PH_STEPS; k++) begin
            s_d[k] = r_d[2*k-1];
            s_n[k] = r_n[2*k-1];
            s_fix[k] = r_fix[2*k-1];
            s_fixlvl[k] = r_fixlvl[2*k-1];
            s_cnt[k] = r_cnt[2*k-1];
        end
    end

    always_comb begin
        logic [TBL_IDX_W-1:0] idx;
        logic                 neg;
        logic [CNT_W-1:0]     diff;
        t_trig                sv;
        t_trig                cv;
        logic signed [MUL_W:0] gap;
        for (int k = 0; k < PH_STEPS; k++) begin
            n_try[k] = s_cnt[k] | (CNT_W'(1) << (PH_STEPS - 1 - k));
            neg = !n_try[k][CNT_W-1];
            diff = CNT_W'(TBL_N) - n_try[k];
            idx = neg ? diff[TBL_IDX_W-1:0] : n_try[k][TBL_IDX_W-1:0];
            cv = COSINE_TBL[idx];
            sv = neg ? -SINE_TBL[idx] : SINE_TBL[idx];
            n_p1[k] = MUL_W'(s_n[k]) * MUL_W'(cv);
            n_p2[k] = MUL_W'(s_d[k]) * MUL_W'(sv);
            gap = (MUL_W + 1)'(r_p1[k]) - (MUL_W + 1)'(r_p2[k]);
            n_cnt[k] = gap[MUL_W] ? r_cnt[2*k] : r_try[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PH_STEPS; k++) begin
            r_d[2*k] <= s_d[k];
            r_n[2*k] <= s_n[k];
            r_fix[2*k] <= s_fix[k];
            r_fixlvl[2*k] <= s_fixlvl[k];
            r_cnt[2*k] <= s_cnt[k];
            r_try[k] <= n_try[k];
            r_p1[k] <= n_p1[k];
            r_p2[k] <= n_p2[k];
            r_d[2*k+1] <= r_d[2*k];
            r_n[2*k+1] <= r_n[2*k];
            r_fix[2*k+1] <= r_fix[2*k];
            r_fixlvl[2*k+1] <= r_fixlvl[2*k];
            r_cnt[2*k+1] <= n_cnt[k];
        end
    end

    // align with the magnitude path
    logic [LEVEL_W-1:0] r_pad [PH_PAD];
    logic [LEVEL_W-1:0] n_lvl;

    always_comb begin
        if (r_fix[2*PH_STEPS-1]) begin
            n_lvl = r_fixlvl[2*PH_STEPS-1];
        end else begin
            n_lvl = PHASE_BASE + LEVEL_W'(r_cnt[2*PH_STEPS-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pad[0] <= n_lvl;
        for (int k = 1; k < PH_PAD; k++) begin
            r_pad[k] <= r_pad[k-1];
        end
    end

    assign o_level = r_pad[PH_PAD-1];

endmodule

>>> rtl/core/spectrum_magnitude_phase_quantizer.sv
// throughput: one request per cycle, busy never rises
// reset: synchronous, active low; clears the valid line and loads clip level 1.0
// the receiver cannot stall, so results leave the pipeline unconditionally
module spectrum_magnitude_phase_quantizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  smpq_pkg::t_req              i_req,
    input  logic                        i_cfg_we,
    input  logic [smpq_pkg::CLIP_W-1:0] i_cfg_data,
    output logic                        o_valid,
    output smpq_pkg::t_res              o_res
);
    import smpq_pkg::*;

    // magnitude path: squares, scale by 510^2, 41-stage bit-per-stage square
    // root, then an 8-stage search for the level against the clip level
    // phase path: half-plane fold, then a 7-step binary search over the
    // angle thresholds (multiply stage + sign stage each), padded to match

    logic [CLIP_W-1:0]  r_clip;
    logic [MAG_LAT-1:0] r_vld;
    logic [LEVEL_W-1:0] w_mag;
    logic [LEVEL_W-1:0] w_phase;
    logic               w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // clip of zero behaves as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= CLIP_RESET;
        end else if (i_cfg_we) begin
            r_clip <= (i_cfg_data == '0) ? CLIP_W'(1) : i_cfg_data;
        end
    end

    // valid bits run alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[MAG_LAT-2:0], w_accept};
        end
    end

    smpq_mag u_mag (
        .i_clk   (i_clk),
        .i_req   (i_req),
        .i_clip  (r_clip),
        .o_level (w_mag)
    );

    smpq_phase u_phase (
        .i_clk   (i_clk),
        .i_req   (i_req),
        .o_level (w_phase)
    );

    assign o_valid               = r_vld[MAG_LAT-1];
    assign o_res.magnitude_level = w_mag;
    assign o_res.phase_level     = w_phase;

`ifndef NO_ASSERTIONS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.phase_level >= PHASE_NEG && o_res.phase_level <= PHASE_POS))
        else $error("phase level out of half-circle range");

    a_clip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_clip != '0))
        else $error("clip level zero after write");

    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |=> r_vld[1])
        else $error("request lost in valid line");
`endif

endmodule
